@@ rtl/core/tvp_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle vertex projector package
// Shared constants and state types for the projector core and its divider.
// ----------------------------------------------------------------------------
package tvp_pkg;

  localparam int MAX_VERTS_DEF = 16384;
  localparam int COORD_W       = 32;
  localparam int COLOR_W       = 24;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int CLIP_W        = 50;
  localparam int DEN_W         = 49;
  localparam int W_MIN_RAW     = 6;
  localparam int FRAC_BITS     = 16;

  localparam logic [COORD_W-1:0] NDC_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] NDC_MIN = 32'h8000_0000;

  localparam logic KIND_VERTEX  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_CHECK,
    S_DIV,
    S_FINISH,
    S_EMIT
  } tvp_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_LOAD,
    D_STEP,
    D_DONE
  } div_state_t;

endpackage

@@ rtl/core/tvp_div.sv @@
// ----------------------------------------------------------------------------
// Projector serial divider
// Bit-serial restoring division of a signed clip coordinate by a positive
// clip w, giving a Q16.16 quotient truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module tvp_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [tvp_pkg::CLIP_W-1:0] num,
  input  logic        [tvp_pkg::DEN_W-1:0]  den,
  output logic                             done,
  output logic        [tvp_pkg::COORD_W-1:0] quot
);
  import tvp_pkg::*;

  div_state_t        state;
  div_state_t        state_next;
  logic              neg;
  logic              sat;
  logic [CLIP_W-1:0] mag;
  logic [DEN_W-1:0]  dval;
  logic [DEN_W-1:0]  rem;
  logic [30:0]       sr;
  logic [30:0]       q;
  logic [4:0]        cnt;
  logic [DEN_W:0]    r2;
  logic [COORD_W-1:0] qpos;

  assign r2 = {rem, sr[30]};

  always_comb begin
    state_next = state;
    case (state)
      D_IDLE: begin
        if (start) begin
          state_next = D_LOAD;
        end
      end
      D_LOAD: begin
        if (mag >= {1'b0, dval, 15'b0}) begin
          state_next = D_DONE;
        end else begin
          state_next = D_STEP;
        end
      end
      D_STEP: begin
        if (cnt == 5'd30) begin
          state_next = D_DONE;
        end
      end
      D_DONE: begin
        if (start) begin
          state_next = D_LOAD;
        end else begin
          state_next = D_IDLE;
        end
      end
      default: begin
        state_next = D_IDLE;
      end
    endcase
  end

  always_comb begin
    done = (state == D_DONE);
    qpos = {1'b0, q};
    if (sat) begin
      quot = neg ? NDC_MIN : NDC_MAX;
    end else if (neg) begin
      quot = ~qpos + 32'd1;
    end else begin
      quot = qpos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE, D_DONE: begin
        if (start) begin
          neg  <= num[CLIP_W-1];
          mag  <= num[CLIP_W-1] ? (~num + 1'b1) : num;
          dval <= den;
        end
      end
      D_LOAD: begin
        sat <= (mag >= {1'b0, dval, 15'b0});
        rem <= {14'b0, mag[CLIP_W-1:15]};
        sr  <= {mag[14:0], 16'b0};
        q   <= '0;
        cnt <= '0;
      end
      D_STEP: begin
        if (r2 >= {1'b0, dval}) begin
          rem <= DEN_W'(r2 - {1'b0, dval});
          q   <= {q[29:0], 1'b1};
        end else begin
          rem <= r2[DEN_W-1:0];
          q   <= {q[29:0], 1'b0};
        end
        sr  <= {sr[29:0], 1'b0};
        cnt <= cnt + 5'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/triangle_vertex_projector.sv @@
// ----------------------------------------------------------------------------
// Triangle vertex projector
// Transforms vertices by a 4x4 Q16.16 matrix, divides by clip w and emits
// whole triangles that pass the w test while the batch has room.
// ----------------------------------------------------------------------------
// One request is taken at a time. A vertex passes through the shared 32x32
// multiplier (16 products, each multiplied then accumulated, the fourth
// column as the bare entry), the w test and, if w passes, the bit-serial
// divider for each of x, y and z (ending early on a saturating quotient);
// a rejected vertex skips the divider. A frame restart is taken in the
// idle state. The third vertex of an emitted triangle is followed by three
// output requests, one per cycle while the consumer is ready.
module triangle_vertex_projector #(
  parameter int MAX_VERTS = tvp_pkg::MAX_VERTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tvp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tvp_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               kind,
  input  logic signed [tvp_pkg::COORD_W-1:0] pos_x,
  input  logic signed [tvp_pkg::COORD_W-1:0] pos_y,
  input  logic signed [tvp_pkg::COORD_W-1:0] pos_z,
  input  logic [tvp_pkg::COLOR_W-1:0]        vertex_color,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tvp_pkg::COORD_W-1:0] ndc_x,
  output logic signed [tvp_pkg::COORD_W-1:0] ndc_y,
  output logic signed [tvp_pkg::COORD_W-1:0] ndc_z,
  output logic [7:0]                         red,
  output logic [7:0]                         green,
  output logic [7:0]                         blue,
  output logic                               last
);
  import tvp_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTS + 1);

  tvp_state_t state;
  tvp_state_t state_next;

  logic signed [COORD_W-1:0] mat [16];
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] pz;
  logic [COLOR_W-1:0]        color;
  logic [1:0]                row;
  logic [1:0]                col;
  logic [1:0]                crd;
  logic signed [63:0]        prod;
  logic signed [CLIP_W-1:0]  acc;
  logic signed [CLIP_W-1:0]  acc_sum;
  logic signed [CLIP_W-1:0]  clip [4];
  logic [COORD_W-1:0]        res [3];
  logic [COORD_W-1:0]        held_x [2];
  logic [COORD_W-1:0]        held_y [2];
  logic [COORD_W-1:0]        held_z [2];
  logic [COLOR_W-1:0]        held_color [2];
  logic [1:0]                slot_index;
  logic                      triangle_bad;
  logic [CNT_W-1:0]          vertices_queued;
  logic [CNT_W:0]            queued_plus;
  logic [1:0]                emit_idx;
  logic signed [COORD_W-1:0] m_sel;
  logic signed [COORD_W-1:0] p_sel;
  logic                      w_low;
  logic                      div_start;
  logic                      div_done;
  logic signed [CLIP_W-1:0]  div_num;
  logic [COORD_W-1:0]        div_quot;
  logic [COLOR_W-1:0]        out_color;

  assign m_sel       = mat[{col, row}];
  assign acc_sum     = acc + CLIP_W'($signed(prod[63:FRAC_BITS]));
  assign w_low       = (clip[3] <= CLIP_W'(W_MIN_RAW));
  assign queued_plus = {1'b0, vertices_queued} + (CNT_W + 1)'(3);
  assign div_num     = (state == S_CHECK) ? clip[0] : clip[crd + 2'd1];

  always_comb begin
    case (col)
      2'd0:    p_sel = px;
      2'd1:    p_sel = py;
      default: p_sel = pz;
    endcase
  end

  tvp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (clip[3][DEN_W-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && kind == KIND_VERTEX) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        if (col == 2'd3 && row == 2'd3) begin
          state_next = S_CHECK;
        end else begin
          state_next = S_MUL;
        end
      end
      S_CHECK: begin
        state_next = w_low ? S_FINISH : S_DIV;
      end
      S_DIV: begin
        if (div_done && crd == 2'd2) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_index == 2'd2 && !triangle_bad &&
            queued_plus <= (CNT_W + 1)'(MAX_VERTS)) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_ready && emit_idx == 2'd2) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_EMIT);
    div_start = (state == S_CHECK && !w_low) ||
                (state == S_DIV && div_done && crd != 2'd2);
  end

  always_comb begin
    case (emit_idx)
      2'd0: begin
        ndc_x     = held_x[0];
        ndc_y     = held_y[0];
        ndc_z     = held_z[0];
        out_color = held_color[0];
      end
      2'd1: begin
        ndc_x     = held_x[1];
        ndc_y     = held_y[1];
        ndc_z     = held_z[1];
        out_color = held_color[1];
      end
      default: begin
        ndc_x     = res[0];
        ndc_y     = res[1];
        ndc_z     = res[2];
        out_color = color;
      end
    endcase
    red   = out_color[23:16];
    green = out_color[15:8];
    blue  = out_color[7:0];
    last  = (emit_idx == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= '0;
      end
    end else if (cfg_we) begin
      mat[{cfg_index, 1'b0}] <= cfg_wdata[31:0];
      mat[{cfg_index, 1'b1}] <= cfg_wdata[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      slot_index      <= '0;
      triangle_bad    <= 1'b0;
      vertices_queued <= '0;
      emit_idx        <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_valid && kind == KIND_RESTART) begin
            slot_index      <= '0;
            triangle_bad    <= 1'b0;
            vertices_queued <= '0;
          end
        end
        S_CHECK: begin
          if (w_low) begin
            triangle_bad <= 1'b1;
          end
        end
        S_FINISH: begin
          if (slot_index == 2'd2) begin
            slot_index   <= '0;
            triangle_bad <= 1'b0;
            emit_idx     <= '0;
            if (!triangle_bad && queued_plus <= (CNT_W + 1)'(MAX_VERTS)) begin
              vertices_queued <= queued_plus[CNT_W-1:0];
            end
          end else begin
            slot_index <= slot_index + 2'd1;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        px    <= pos_x;
        py    <= pos_y;
        pz    <= pos_z;
        color <= vertex_color;
        row   <= '0;
        col   <= '0;
        acc   <= '0;
      end
      S_MUL: begin
        if (col == 2'd3) begin
          prod <= {{(64 - COORD_W - FRAC_BITS){m_sel[COORD_W-1]}}, m_sel, 16'b0};
        end else begin
          prod <= m_sel * p_sel;
        end
      end
      S_ACC: begin
        if (col == 2'd3) begin
          clip[row] <= acc_sum;
          acc       <= '0;
          row       <= row + 2'd1;
          col       <= '0;
        end else begin
          acc <= acc_sum;
          col <= col + 2'd1;
        end
      end
      S_CHECK: begin
        crd <= '0;
        if (w_low) begin
          res[0] <= '0;
          res[1] <= '0;
          res[2] <= '0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res[crd] <= div_quot;
          crd      <= crd + 2'd1;
        end
      end
      S_FINISH: begin
        if (slot_index != 2'd2) begin
          held_x[slot_index[0]]     <= res[0];
          held_y[slot_index[0]]     <= res[1];
          held_z[slot_index[0]]     <= res[2];
          held_color[slot_index[0]] <= color;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
